[sv/otld_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered task list dispatcher package
// Sizes, request and status codes, and the per-cell control struct shared by
// the cells, the top level and the checker.
// ----------------------------------------------------------------------------
package otld_pkg;

	localparam int MAX_TASKS    = 8;
	localparam int TASK_ID_BITS = 8;

	// Count and cursor must hold MAX_TASKS itself; an index only needs the depth.
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	typedef logic [TASK_ID_BITS-1:0] id_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [IDX_W-1:0]        idx_t;

	typedef enum logic [1:0] {
		REQ_ADD      = 2'd0,
		REQ_REMOVE   = 2'd1,
		REQ_DISPATCH = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_PRESENT   = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// Write controls that the top level sends to every cell.
	typedef struct packed {
		logic load;      // take the request identifier
		logic shift_en;  // a remove is under way: cells at or past the hit take the neighbor
	} cell_ctl_t;

endpackage

[sv/ordered_task_list_dispatcher.sv]
// ----------------------------------------------------------------------------
// Ordered task list dispatcher
// Keeps a compacted, ordered list of task identifiers in a row of cells and
// hands them out round robin on dispatch requests.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake           Payload
//   --------  ------------------  -------------------------------------------
//   request   start / busy        req_type, task_id
//   result    done (one cycle)    status, next_task, next_valid, task_count
//
// Every request is accepted at the edge where start is high and busy is low,
// and its result shows in the next cycle with done high. The cell row compares
// all entries and closes a remove gap in one step, so busy stays low and a new
// request may be accepted in every cycle.
// Reset (arst_n low) empties the list, clears the cursor and the restart mark
// and drops done. The receiver cannot stall: each result is taken when shown.
//
module ordered_task_list_dispatcher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] req_type,
	input  logic [7:0] task_id,
	output logic       done,
	output logic [2:0] status,
	output logic [7:0] next_task,
	output logic       next_valid,
	output logic [3:0] task_count
);

	// List state.
	otld_pkg::cnt_t count_q;
	otld_pkg::cnt_t cursor_q;
	logic           restart_q;

	// Result register.
	logic              done_q;
	otld_pkg::status_t status_q;
	otld_pkg::id_t     next_q;
	logic              valid_q;

	// Cell row wiring.
	otld_pkg::id_t     key;
	otld_pkg::id_t     ids  [otld_pkg::MAX_TASKS];
	logic              seen [otld_pkg::MAX_TASKS+1];
	otld_pkg::cell_ctl_t ctl [otld_pkg::MAX_TASKS];
	logic              found;

	// Decoded request and next state.
	logic              accept;
	logic              add_ok;
	logic              rem_ok;
	otld_pkg::cnt_t    count_d;
	otld_pkg::cnt_t    cursor_d;
	logic              restart_d;
	otld_pkg::cnt_t    eff_cur;
	otld_pkg::status_t status_d;
	otld_pkg::id_t     next_d;
	logic              valid_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign key    = task_id[otld_pkg::TASK_ID_BITS-1:0];

	// The hit mark runs up the row from the first cell; the last output tells
	// whether the identifier is in the list at all.
	assign seen[0] = 1'b0;
	assign found   = seen[otld_pkg::MAX_TASKS];

	for (genvar i = 0; i < otld_pkg::MAX_TASKS; i++) begin : g_cell
		otld_pkg::id_t nbr;

		if (i + 1 < otld_pkg::MAX_TASKS) begin : g_mid
			assign nbr = ids[i+1];
		end else begin : g_end
			assign nbr = ids[i];
		end

		// An add lands in the first free cell, right at the count.
		assign ctl[i].load     = add_ok && (count_q == otld_pkg::cnt_t'(i));
		assign ctl[i].shift_en = rem_ok;

		otld_cell u_cell (
			.clk     (clk),
			.live    (otld_pkg::cnt_t'(i) < count_q),
			.key     (key),
			.ctl     (ctl[i]),
			.seen_in (seen[i]),
			.nbr_id  (nbr),
			.seen_out(seen[i+1]),
			.id      (ids[i])
		);
	end

	// The restart mark, or a cursor that has run past the end (after removes),
	// sends the dispatch back to the first entry.
	assign eff_cur = (restart_q || (cursor_q >= count_q)) ? '0 : cursor_q;

	always_comb begin
		add_ok    = 1'b0;
		rem_ok    = 1'b0;
		count_d   = count_q;
		cursor_d  = cursor_q;
		restart_d = restart_q;
		status_d  = otld_pkg::ST_OK;
		next_d    = '0;
		valid_d   = 1'b0;
		if (accept) begin
			unique case (req_type)
				otld_pkg::REQ_ADD: begin
					if (found) begin
						status_d = otld_pkg::ST_PRESENT;
					end else if (count_q >= otld_pkg::cnt_t'(otld_pkg::MAX_TASKS)) begin
						status_d = otld_pkg::ST_FULL;
					end else begin
						add_ok  = 1'b1;
						count_d = count_q + otld_pkg::cnt_t'(1);
					end
				end
				otld_pkg::REQ_REMOVE: begin
					if (!found) begin
						status_d = otld_pkg::ST_NOT_FOUND;
					end else begin
						rem_ok    = 1'b1;
						count_d   = count_q - otld_pkg::cnt_t'(1);
						restart_d = 1'b1;
					end
				end
				otld_pkg::REQ_DISPATCH: begin
					restart_d = 1'b0;
					if (count_q == '0) begin
						status_d = otld_pkg::ST_EMPTY;
						cursor_d = '0;
					end else begin
						next_d   = ids[eff_cur[otld_pkg::IDX_W-1:0]];
						valid_d  = 1'b1;
						cursor_d = eff_cur + otld_pkg::cnt_t'(1);
					end
				end
				default: begin
					// Undefined request type: answered with ok, nothing changes.
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			cursor_q  <= '0;
			restart_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			count_q   <= count_d;
			cursor_q  <= cursor_d;
			restart_q <= restart_d;
			done_q    <= accept;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		next_q   <= next_d;
		valid_q  <= valid_d;
	end

	assign done       = done_q;
	assign status     = status_q;
	assign next_task  = 8'(next_q);
	assign next_valid = valid_q;
	assign task_count = 4'(count_q);

endmodule

[sv/otld_cell.sv]
// ----------------------------------------------------------------------------
// Task list cell
// Holds one list entry, compares it with the request identifier, and passes
// the "hit seen so far" mark and its entry along the row.
// ----------------------------------------------------------------------------
module otld_cell (
	input  logic              clk,
	input  logic              live,      // entry lies below the current count
	input  otld_pkg::id_t     key,
	input  otld_pkg::cell_ctl_t ctl,
	input  logic              seen_in,   // a hit exists in an earlier cell
	input  otld_pkg::id_t     nbr_id,    // entry of the next cell up the row
	output logic              seen_out,
	output otld_pkg::id_t     id
);

	otld_pkg::id_t id_q;
	logic          hit;

	assign hit      = live && (id_q == key);
	assign seen_out = seen_in || hit;
	assign id       = id_q;

	// On remove, every cell from the matching one upward takes its neighbor,
	// which closes the gap in one step.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			id_q <= key;
		end else if (ctl.shift_en && seen_out) begin
			id_q <= nbr_id;
		end
	end

endmodule

[sv/otld_checker.sv]
// ----------------------------------------------------------------------------
// Ordered task list dispatcher checker
// Port-level checks on the request/result timing and on result consistency.
// ----------------------------------------------------------------------------
module otld_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [2:0] status,
	input logic       next_valid,
	input logic [3:0] task_count
);

	// Every accepted request is answered in the next cycle.
	a_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("request not answered");

	// No result without a request in the previous cycle.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without request");

	// The list never reports more entries than it can hold.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (task_count <= 4'(otld_pkg::MAX_TASKS)))
		else $error("task count out of range");

	// A dispatched task comes with ok status and a non-empty list.
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && next_valid) |-> (status == otld_pkg::ST_OK && task_count != 4'd0))
		else $error("dispatch result inconsistent");

	// An empty report means the list really is empty.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == otld_pkg::ST_EMPTY) |-> (task_count == 4'd0 && !next_valid))
		else $error("empty status with tasks present");

endmodule

bind ordered_task_list_dispatcher otld_checker u_otld_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.next_valid (next_valid),
	.task_count (task_count)
);

[dv/ordered_task_list_dispatcher_tb.sv]
// ----------------------------------------------------------------------------
// Ordered task list dispatcher testbench
// Drives add, remove, dispatch and ignored requests into the dispatcher and
// checks every result against a cycle-free model of the task list, the
// round-robin cursor and the restart mark kept inside this bench.
// ----------------------------------------------------------------------------
module ordered_task_list_dispatcher_tb;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_REQS  = 1750;
	localparam int PHASE_LEN    = 125;
	localparam int DRAIN_CYCLES = 8;
	localparam int WATCHDOG_CYC = 200000;
	localparam int POOL_SIZE    = 12;

	// The request code that the block must ignore; the package leaves it unnamed.
	localparam logic [1:0] REQ_IGNORED = 2'd3;

	// Sender idle rate per phase, in percent; phases rotate as requests go in.
	localparam int IDLE_PCT [3] = '{0, 77, 14};

	// Random stimulus moods: grow the list, shrink it, or stir it evenly.
	typedef enum int {MOOD_FILL, MOOD_DRAIN, MOOD_MIXED} mood_t;

	typedef struct {
		logic [1:0]    req;
		otld_pkg::id_t id;
	} request_t;

	typedef struct {
		otld_pkg::status_t status;
		otld_pkg::id_t     next_task;
		logic              next_valid;
		logic [3:0]        task_count;
	} outcome_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       start      = 1'b0;
	logic [1:0] req_type   = otld_pkg::REQ_ADD;
	logic [7:0] task_id    = '0;
	logic       busy;
	logic       done;
	logic [2:0] status;
	logic [7:0] next_task;
	logic       next_valid;
	logic [3:0] task_count;

	request_t pending_requests[$];
	outcome_t expected_outcomes[$];
	int       accepted_cnt = 0;
	int       mismatches   = 0;
	int       idle_pct;
	request_t drive_req;

	// Shadow of the block's state: the compacted list, its length, the
	// dispatch cursor and the restart mark set by a successful remove.
	otld_pkg::id_t list_ids [otld_pkg::MAX_TASKS];
	int  list_len    = 0;
	int  cursor      = 0;
	bit  restart_mrk = 1'b0;

	ordered_task_list_dispatcher i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.task_id    (task_id),
		.done       (done),
		.status     (status),
		.next_task  (next_task),
		.next_valid (next_valid),
		.task_count (task_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Applies one request to the shadow list and returns the result the block
	// must show for it.
	function automatic outcome_t apply_request(logic [1:0] req, otld_pkg::id_t id);
		outcome_t res;
		int       pos;
		res.status     = otld_pkg::ST_OK;
		res.next_task  = '0;
		res.next_valid = 1'b0;
		pos = otld_pkg::MAX_TASKS;
		for (int i = 0; i < list_len; i++) begin
			if (pos == otld_pkg::MAX_TASKS && list_ids[i] == id)
				pos = i;
		end
		case (req)
			otld_pkg::REQ_ADD: begin
				if (pos < otld_pkg::MAX_TASKS)
					res.status = otld_pkg::ST_PRESENT;
				else if (list_len >= otld_pkg::MAX_TASKS)
					res.status = otld_pkg::ST_FULL;
				else begin
					list_ids[list_len] = id;
					list_len++;
				end
			end
			otld_pkg::REQ_REMOVE: begin
				if (pos == otld_pkg::MAX_TASKS)
					res.status = otld_pkg::ST_NOT_FOUND;
				else begin
					// Later entries slide down one place to close the gap.
					for (int i = pos; i + 1 < list_len; i++)
						list_ids[i] = list_ids[i + 1];
					list_len--;
					restart_mrk = 1'b1;
				end
			end
			otld_pkg::REQ_DISPATCH: begin
				// The cursor rewinds before the pick when a remove has set the restart
				// mark or when it has run past the last entry.
				if (restart_mrk || cursor >= list_len) begin
					cursor      = 0;
					restart_mrk = 1'b0;
				end
				if (list_len == 0)
					res.status = otld_pkg::ST_EMPTY;
				else begin
					res.next_task  = list_ids[cursor];
					res.next_valid = 1'b1;
					cursor++;
				end
			end
			default: begin
				// An undefined request type leaves everything as it is.
			end
		endcase
		res.task_count = list_len[3:0];
		return res;
	endfunction

	// Driver. A request is taken at an edge where start is high and busy is
	// low; the model is advanced at that same edge so that expectations line up
	// with the order of acceptance. While start is low the request fields carry
	// junk, which the block must not act on.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_outcomes.push_back(apply_request(req_type, task_id));
				accepted_cnt++;
			end
			idle_pct = IDLE_PCT[(accepted_cnt / PHASE_LEN) % 3];
			// A request that is still waiting on busy is held unchanged.
			if (!(start && busy)) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
					drive_req = pending_requests.pop_front();
					start    <= 1'b1;
					req_type <= drive_req.req;
					task_id  <= drive_req.id;
				end else begin
					start    <= 1'b0;
					req_type <= 2'($urandom);
					task_id  <= 8'($urandom);
				end
			end
		end
	end

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Monitor. done is high for exactly one cycle per result and the block
	// cannot be held off, so every edge with done high carries a result.
	always @(posedge clk) begin
		if (arst_n && done !== 1'b0) begin
			if (expected_outcomes.size() == 0) begin
				$error("result with no request outstanding: status %0d next_task %0d",
					status, next_task);
				mismatches++;
			end else begin
				outcome_t want;
				want = expected_outcomes.pop_front();
				check_field("status",     8'(want.status),     8'(status));
				check_field("next_task",  8'(want.next_task),  next_task);
				check_field("next_valid", 8'(want.next_valid), 8'(next_valid));
				check_field("task_count", 8'(want.task_count), 8'(task_count));
			end
		end
	end

	task automatic queue_request(logic [1:0] req, otld_pkg::id_t id);
		request_t rq;
		rq.req = req;
		rq.id  = id;
		pending_requests.push_back(rq);
	endtask

	initial begin
		otld_pkg::id_t id_pool [POOL_SIZE];
		mood_t         mood;
		int            roll;
		int            add_pct;
		int            rem_pct;
		otld_pkg::id_t pick;

		// Directed part. It fills the list from empty to full and then shrinks it,
		// reaching every status code, with identifiers that set and clear every bit.
		queue_request(otld_pkg::REQ_DISPATCH, 8'h00);  // dispatch from an empty list
		queue_request(otld_pkg::REQ_REMOVE,   8'h05);  // remove from an empty list
		queue_request(REQ_IGNORED,            8'hAA);  // undefined type on an empty list
		queue_request(otld_pkg::REQ_ADD,      8'h00);
		queue_request(otld_pkg::REQ_ADD,      8'hFF);
		queue_request(otld_pkg::REQ_ADD,      8'hFF);  // already present
		queue_request(otld_pkg::REQ_DISPATCH, 8'h00);
		foreach (id_pool[i])
			id_pool[i] = '0;
		queue_request(otld_pkg::REQ_ADD,      8'h55);
		queue_request(otld_pkg::REQ_ADD,      8'hAA);
		queue_request(otld_pkg::REQ_ADD,      8'h01);
		queue_request(otld_pkg::REQ_ADD,      8'h80);
		queue_request(otld_pkg::REQ_ADD,      8'h7E);
		queue_request(otld_pkg::REQ_ADD,      8'h3C);  // list now holds all eight
		queue_request(otld_pkg::REQ_ADD,      8'h99);  // list full
		queue_request(otld_pkg::REQ_ADD,      8'h00);  // present wins over full
		queue_request(otld_pkg::REQ_DISPATCH, 8'h00);
		queue_request(otld_pkg::REQ_DISPATCH, 8'h00);
		queue_request(otld_pkg::REQ_REMOVE,   8'h55);  // middle entry, sets the restart mark
		queue_request(otld_pkg::REQ_DISPATCH, 8'h00);  // rewinds to the head
		queue_request(otld_pkg::REQ_REMOVE,   8'h3C);  // last entry
		queue_request(otld_pkg::REQ_REMOVE,   8'h00);  // first entry
		queue_request(otld_pkg::REQ_REMOVE,   8'h12);  // absent identifier
		queue_request(REQ_IGNORED,            8'h3C);  // undefined type on a filled list
		queue_request(otld_pkg::REQ_DISPATCH, 8'hFF);
		queue_request(otld_pkg::REQ_DISPATCH, 8'h55);

		// Random part. Most identifiers come from a small pool so that adds
		// collide and removes hit; the rest roam the whole range. The mood
		// changes every few dozen requests so the list swings between full and
		// empty, which exercises the cursor at every length.
		id_pool[0] = 8'h00;
		id_pool[1] = 8'hFF;
		for (int i = 2; i < POOL_SIZE; i++)
			id_pool[i] = 8'($urandom);
		mood = MOOD_MIXED;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n % 40 == 0)
				mood = mood_t'($urandom_range(2));
			case (mood)
				MOOD_FILL:  begin add_pct = 60; rem_pct = 15; end
				MOOD_DRAIN: begin add_pct = 15; rem_pct = 60; end
				default:    begin add_pct = 35; rem_pct = 30; end
			endcase
			if ($urandom_range(99) < 80)
				pick = id_pool[$urandom_range(POOL_SIZE - 1)];
			else
				pick = 8'($urandom);
			roll = $urandom_range(99);
			if (roll < 3)
				queue_request(REQ_IGNORED, pick);
			else if (roll < 3 + add_pct)
				queue_request(otld_pkg::REQ_ADD, pick);
			else if (roll < 3 + add_pct + rem_pct)
				queue_request(otld_pkg::REQ_REMOVE, pick);
			else
				queue_request(otld_pkg::REQ_DISPATCH, 8'($urandom));
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the driver to hand over every request, then for every
		// result, then through the drain wait to catch any stray done pulse.
		while (pending_requests.size() != 0 || start)
			@(posedge clk);
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, even at the highest idle rate.
	initial begin
		#(CLK_PERIOD * WATCHDOG_CYC);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
